// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL.
// ASSERT_ALWAYS: cond holds at every rising clock edge outside reset.
// ASSERT_IMPLY:  same-cycle implication.
// ASSERT_NEXT:   next-cycle implication.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_IMPLY(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_IMPLY(lbl, clk, rst_n, pre, post, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ----- src/amst_pkg.sv -----
package amst_pkg;

    // Default table geometry
    localparam int DEF_SLOTS   = 16;
    localparam int DEF_THREADS = 8;

    // Field widths
    localparam int MODE_W   = 2;
    localparam int VALUE_W  = 63;
    localparam int TID_W    = 3;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_HINT,
        S_HCHK,
        S_SCAN,
        S_WRITE,
        S_RESP
    } state_t;

endpackage

// ----- src/amst_if.sv -----
// Request channel
interface amst_in_if;
    logic                           valid;
    logic                           ready;
    logic [amst_pkg::MODE_W-1:0]    mode;
    logic [amst_pkg::VALUE_W-1:0]   seq_value;
    logic [amst_pkg::TID_W-1:0]     thread_id;

    modport source (output valid, mode, seq_value, thread_id, input ready);
    modport sink   (input valid, mode, seq_value, thread_id, output ready);
endinterface

// Result channel
interface amst_out_if;
    logic                           valid;
    logic                           ready;
    logic [amst_pkg::STATUS_W-1:0]  status;
    logic                           min_valid;
    logic [amst_pkg::VALUE_W-1:0]   min_value;

    modport source (output valid, status, min_valid, min_value, input ready);
    modport sink   (input valid, status, min_valid, min_value, output ready);
endinterface

// ----- src/amst_ram.sv -----
// Simple dual-port RAM: one write port, one read port with registered data.
module amst_ram #(
    parameter int WIDTH = amst_pkg::VALUE_W,
    parameter int DEPTH = amst_pkg::DEF_SLOTS
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/aggregate_minimum_slot_table.sv -----
// Channel  Dir   Fields                            Beat taken when
// -------  ----  --------------------------------  ------------------------
// in       sink  mode, seq_value, thread_id        in.valid && in.ready
// out      src   status, min_valid, min_value      out.valid && out.ready
//
// One request at a time. After the accept a request passes S_HINT and S_HCHK;
// a hinted remove, a live-memo query or an unused mode then goes to S_RESP, a
// hinted add via S_WRITE; else S_SCAN reads slots up to high_water (one slot
// read per cycle on the RAM port and shared comparator), then S_WRITE/S_RESP.
// in.ready only while idle; S_RESP waits while a full output reg is not taken.
// Reset clears occupancy, hints, high-water mark and memo; no clearing pass.
`include "assert_macros.svh"

module aggregate_minimum_slot_table #(
    parameter int SLOTS   = amst_pkg::DEF_SLOTS,
    parameter int THREADS = amst_pkg::DEF_THREADS
) (
    input  logic       clk,
    input  logic       rst_n,
    amst_in_if.sink    in,
    amst_out_if.source out
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int HW_W   = $clog2(SLOTS + 1);
    localparam int TIX_W  = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int VW     = amst_pkg::VALUE_W;

    amst_pkg::state_t state_reg, state_next;

    // Request registers
    logic [amst_pkg::MODE_W-1:0]   mode_reg, mode_next;
    logic [VW-1:0]                 val_reg, val_next;
    logic [amst_pkg::TID_W-1:0]    tid_reg, tid_next;
    logic [SLOT_W-1:0]             hslot_reg, hslot_next;
    logic                          hint_ok_reg, hint_ok_next;
    logic [amst_pkg::STATUS_W-1:0] res_status_reg, res_status_next;

    // Scan pipeline
    logic [HW_W-1:0]   idx_reg, idx_next;
    logic              cmp_v_reg, cmp_v_next;
    logic [SLOT_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [SLOT_W-1:0] wr_addr_reg, wr_addr_next;

    // Table state
    logic [HW_W-1:0]    hw_reg, hw_next;
    logic [SLOTS-1:0]   occ_reg, occ_next;
    logic [SLOT_W-1:0]  hint_slot_reg [THREADS];
    logic [SLOT_W-1:0]  hint_slot_next [THREADS];
    logic [THREADS-1:0] hint_valid_reg, hint_valid_next;
    logic               memo_valid_reg, memo_valid_next;
    logic [VW-1:0]      memo_value_reg, memo_value_next;

    // Output register
    logic                          out_valid_reg, out_valid_next;
    logic [amst_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic                          out_min_valid_reg, out_min_valid_next;
    logic [VW-1:0]                 out_min_value_reg, out_min_value_next;

    // RAM port
    logic              ram_we;
    logic [SLOT_W-1:0] ram_raddr;
    logic [VW-1:0]     ram_rdata;

    // Shared comparator
    logic [VW-1:0] cmp_a, cmp_b;
    logic          cmp_lt, cmp_eq;

    // Decision signals
    logic             tid_in;
    logic [TIX_W-1:0] tid_ix;
    logic             hint_ok_now;
    logic             add_hint_hit, rem_hint_hit;
    logic             occ_c, scan_more, scan_done, full;
    logic             add_scan_hit, rem_scan_hit;
    logic             out_free, accept;

    amst_ram #(
        .WIDTH (VW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr_reg),
        .wdata (val_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in.ready      = (state_reg == amst_pkg::S_IDLE);
    assign out.valid     = out_valid_reg;
    assign out.status    = out_status_reg;
    assign out.min_valid = out_min_valid_reg;
    assign out.min_value = out_min_value_reg;

    assign accept   = in.valid && in.ready;
    assign out_free = !out_valid_reg || out.ready;

    // Comparator operand select: memo checks against the request value,
    // scans compare RAM data against the request value or the memo
    always_comb
    begin
        if (state_reg == amst_pkg::S_HINT || state_reg == amst_pkg::S_WRITE)
        begin
            cmp_a = val_reg;
            cmp_b = memo_value_reg;
        end
        else if (mode_reg == amst_pkg::MODE_REMOVE)
        begin
            cmp_a = ram_rdata;
            cmp_b = val_reg;
        end
        else
        begin
            cmp_a = ram_rdata;
            cmp_b = memo_value_reg;
        end
    end

    assign cmp_lt = cmp_a < cmp_b;
    assign cmp_eq = cmp_a == cmp_b;

    // Hint lookup and scan decisions
    always_comb
    begin
        tid_in       = 32'(tid_reg) < 32'(THREADS);
        tid_ix       = TIX_W'(tid_reg);
        hint_ok_now  = tid_in && hint_valid_reg[tid_ix]
                       && (HW_W'(hint_slot_reg[tid_ix]) < hw_reg);
        add_hint_hit = hint_ok_reg && !occ_reg[hslot_reg];
        rem_hint_hit = hint_ok_reg && occ_reg[hslot_reg] && cmp_eq;
        occ_c        = occ_reg[cmp_idx_reg];
        scan_more    = idx_reg < hw_reg;
        scan_done    = !scan_more && !cmp_v_reg;
        full         = hw_reg == HW_W'(SLOTS);
        add_scan_hit = cmp_v_reg && !occ_c;
        rem_scan_hit = cmp_v_reg && occ_c && cmp_eq;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            amst_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = amst_pkg::S_HINT;
                end
            end
            amst_pkg::S_HINT:
            begin
                state_next = amst_pkg::S_HCHK;
            end
            amst_pkg::S_HCHK:
            begin
                priority case (mode_reg)
                    amst_pkg::MODE_ADD:
                        state_next = add_hint_hit ? amst_pkg::S_WRITE : amst_pkg::S_SCAN;
                    amst_pkg::MODE_REMOVE:
                        state_next = rem_hint_hit ? amst_pkg::S_RESP : amst_pkg::S_SCAN;
                    amst_pkg::MODE_QUERY:
                        state_next = memo_valid_reg ? amst_pkg::S_RESP : amst_pkg::S_SCAN;
                    default:
                        state_next = amst_pkg::S_RESP;
                endcase
            end
            amst_pkg::S_SCAN:
            begin
                priority if (mode_reg == amst_pkg::MODE_ADD && add_scan_hit)
                begin
                    state_next = amst_pkg::S_WRITE;
                end
                else if (mode_reg == amst_pkg::MODE_ADD && scan_done)
                begin
                    state_next = full ? amst_pkg::S_RESP : amst_pkg::S_WRITE;
                end
                else if (mode_reg == amst_pkg::MODE_REMOVE && rem_scan_hit)
                begin
                    state_next = amst_pkg::S_RESP;
                end
                else if (scan_done)
                begin
                    state_next = amst_pkg::S_RESP;
                end
                else
                begin
                    state_next = amst_pkg::S_SCAN;
                end
            end
            amst_pkg::S_WRITE:
            begin
                state_next = amst_pkg::S_RESP;
            end
            amst_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    state_next = amst_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = amst_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        mode_next          = mode_reg;
        val_next           = val_reg;
        tid_next           = tid_reg;
        hslot_next         = hslot_reg;
        hint_ok_next       = hint_ok_reg;
        res_status_next    = res_status_reg;
        idx_next           = idx_reg;
        cmp_v_next         = cmp_v_reg;
        cmp_idx_next       = cmp_idx_reg;
        wr_addr_next       = wr_addr_reg;
        hw_next            = hw_reg;
        occ_next           = occ_reg;
        hint_slot_next     = hint_slot_reg;
        hint_valid_next    = hint_valid_reg;
        memo_valid_next    = memo_valid_reg;
        memo_value_next    = memo_value_reg;
        out_valid_next     = out_valid_reg;
        out_status_next    = out_status_reg;
        out_min_valid_next = out_min_valid_reg;
        out_min_value_next = out_min_value_reg;
        ram_we             = 1'b0;
        ram_raddr          = idx_reg[SLOT_W-1:0];

        // result beat taken
        if (out_valid_reg && out.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            amst_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    mode_next       = in.mode;
                    val_next        = in.seq_value;
                    tid_next        = in.thread_id;
                    res_status_next = amst_pkg::ST_OK;
                end
            end
            amst_pkg::S_HINT:
            begin
                // read hinted slot; a remove drops a matching memo up front
                ram_raddr    = hint_slot_reg[tid_ix];
                hslot_next   = hint_slot_reg[tid_ix];
                hint_ok_next = hint_ok_now;
                idx_next     = '0;
                cmp_v_next   = 1'b0;
                if (mode_reg == amst_pkg::MODE_REMOVE && memo_valid_reg && cmp_eq)
                begin
                    memo_valid_next = 1'b0;
                end
            end
            amst_pkg::S_HCHK:
            begin
                if (mode_reg == amst_pkg::MODE_ADD && add_hint_hit)
                begin
                    wr_addr_next = hslot_reg;
                end
                if (mode_reg == amst_pkg::MODE_REMOVE && rem_hint_hit)
                begin
                    occ_next[hslot_reg] = 1'b0;
                end
            end
            amst_pkg::S_SCAN:
            begin
                // issue next slot read
                if (scan_more)
                begin
                    cmp_v_next   = 1'b1;
                    cmp_idx_next = idx_reg[SLOT_W-1:0];
                    idx_next     = idx_reg + HW_W'(1);
                end
                else
                begin
                    cmp_v_next = 1'b0;
                end

                // evaluate slot read last cycle
                priority case (mode_reg)
                    amst_pkg::MODE_ADD:
                    begin
                        if (add_scan_hit)
                        begin
                            cmp_v_next   = 1'b0;
                            wr_addr_next = cmp_idx_reg;
                            if (tid_in)
                            begin
                                hint_slot_next[tid_ix]  = cmp_idx_reg;
                                hint_valid_next[tid_ix] = 1'b1;
                            end
                        end
                        else if (scan_done)
                        begin
                            if (full)
                            begin
                                res_status_next = amst_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_addr_next = hw_reg[SLOT_W-1:0];
                                hw_next      = hw_reg + HW_W'(1);
                                if (tid_in)
                                begin
                                    hint_slot_next[tid_ix]  = hw_reg[SLOT_W-1:0];
                                    hint_valid_next[tid_ix] = 1'b1;
                                end
                            end
                        end
                    end
                    amst_pkg::MODE_REMOVE:
                    begin
                        if (rem_scan_hit)
                        begin
                            cmp_v_next            = 1'b0;
                            occ_next[cmp_idx_reg] = 1'b0;
                        end
                        else if (scan_done)
                        begin
                            res_status_next = amst_pkg::ST_MISSING;
                        end
                    end
                    amst_pkg::MODE_QUERY:
                    begin
                        if (cmp_v_reg && occ_c && (!memo_valid_reg || cmp_lt))
                        begin
                            memo_valid_next = 1'b1;
                            memo_value_next = ram_rdata;
                        end
                    end
                    default:
                    begin
                        cmp_v_next = 1'b0;
                    end
                endcase
            end
            amst_pkg::S_WRITE:
            begin
                ram_we                = 1'b1;
                occ_next[wr_addr_reg] = 1'b1;
                if (memo_valid_reg && cmp_lt)
                begin
                    memo_value_next = val_reg;
                end
            end
            amst_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_status_next    = res_status_reg;
                    out_min_valid_next = (mode_reg == amst_pkg::MODE_QUERY) && memo_valid_reg;
                    out_min_value_next = out_min_valid_next ? memo_value_reg : '0;
                end
            end
            default:
            begin
                cmp_v_next = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= amst_pkg::S_IDLE;
            cmp_v_reg      <= 1'b0;
            hw_reg         <= '0;
            occ_reg        <= '0;
            hint_valid_reg <= '0;
            memo_valid_reg <= 1'b0;
            memo_value_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cmp_v_reg      <= cmp_v_next;
            hw_reg         <= hw_next;
            occ_reg        <= occ_next;
            hint_valid_reg <= hint_valid_next;
            memo_valid_reg <= memo_valid_next;
            memo_value_reg <= memo_value_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mode_reg          <= mode_next;
        val_reg           <= val_next;
        tid_reg           <= tid_next;
        hslot_reg         <= hslot_next;
        hint_ok_reg       <= hint_ok_next;
        res_status_reg    <= res_status_next;
        idx_reg           <= idx_next;
        cmp_idx_reg       <= cmp_idx_next;
        wr_addr_reg       <= wr_addr_next;
        hint_slot_reg     <= hint_slot_next;
        out_status_reg    <= out_status_next;
        out_min_valid_reg <= out_min_valid_next;
        out_min_value_reg <= out_min_value_next;
    end

    // Checks
    `ASSERT_ALWAYS(a_hw_bound, clk, rst_n, hw_reg <= HW_W'(SLOTS), "high-water mark past table size")
    `ASSERT_IMPLY(a_cmp_in_scan, clk, rst_n, cmp_v_reg, state_reg == amst_pkg::S_SCAN, "scan stage live outside scan")
    `ASSERT_NEXT(a_resp_load, clk, rst_n, state_reg == amst_pkg::S_RESP && out_free, out_valid_reg && state_reg == amst_pkg::S_IDLE, "result not loaded")
    `ASSERT_IMPLY(a_full_hw, clk, rst_n, out_valid_reg && out_status_reg == amst_pkg::ST_FULL, hw_reg == HW_W'(SLOTS), "full status with room left")

endmodule

// ----- verif/min_table_checker.sv -----
module min_table_checker
    import amst_pkg::*;
#(
    parameter int SLOTS   = DEF_SLOTS,
    parameter int THREADS = DEF_THREADS
) (
    input  logic       clk,
    input  logic       rst_n,
    amst_in_if         in_ch,
    amst_out_if        out_ch,
    output int         error_count,
    output int         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                min_valid;
        logic [VALUE_W-1:0]  min_value;
    } table_result_t;

    // Shadow copy of the slot table
    logic [VALUE_W-1:0] slot_val [SLOTS];
    bit                 slot_used [SLOTS];
    int unsigned        fill_mark;
    int unsigned        hint_slot [THREADS];
    bit                 hint_ok [THREADS];
    bit                 memo_ok;
    logic [VALUE_W-1:0] memo_min;

    table_result_t expected_results [$];
    int            mismatches;

    // Apply one request to the shadow table and return the result it gives
    function automatic table_result_t table_step(
        input logic [MODE_W-1:0]  op,
        input logic [VALUE_W-1:0] value,
        input logic [TID_W-1:0]   tid
    );
        table_result_t res;
        int unsigned   h;
        int unsigned   pick;
        bit            use_hint;
        bit            found;

        res      = '0;
        use_hint = 1'b0;
        h        = 0;
        if (int'(tid) < THREADS && hint_ok[tid] && hint_slot[tid] < fill_mark
            && hint_slot[tid] < SLOTS)
        begin
            use_hint = 1'b1;
            h        = hint_slot[tid];
        end

        case (op)
            MODE_ADD:
            begin
                if (use_hint && !slot_used[h])
                begin
                    slot_val[h]  = value;
                    slot_used[h] = 1'b1;
                end
                else
                begin
                    // lowest hole below the mark, else grow the mark
                    found = 1'b0;
                    pick  = fill_mark;
                    for (int unsigned i = 0; i < fill_mark && i < SLOTS; i++)
                    begin
                        if (!found && !slot_used[i])
                        begin
                            found = 1'b1;
                            pick  = i;
                        end
                    end
                    if (!found)
                    begin
                        if (fill_mark >= SLOTS)
                        begin
                            res.status = ST_FULL;
                            return res;
                        end
                        pick      = fill_mark;
                        fill_mark = fill_mark + 1;
                    end
                    slot_val[pick]  = value;
                    slot_used[pick] = 1'b1;
                    if (int'(tid) < THREADS)
                    begin
                        hint_slot[tid] = pick;
                        hint_ok[tid]   = 1'b1;
                    end
                end
                if (memo_ok && memo_min > value)
                    memo_min = value;
                res.status = ST_OK;
            end
            MODE_REMOVE:
            begin
                // memo goes on a matching value even if the remove misses
                if (memo_ok && memo_min == value)
                    memo_ok = 1'b0;
                if (use_hint && slot_used[h] && slot_val[h] == value)
                begin
                    slot_used[h] = 1'b0;
                    res.status   = ST_OK;
                    return res;
                end
                for (int unsigned i = 0; i < fill_mark && i < SLOTS; i++)
                begin
                    if (slot_used[i] && slot_val[i] == value)
                    begin
                        slot_used[i] = 1'b0;
                        res.status   = ST_OK;
                        return res;
                    end
                end
                res.status = ST_MISSING;
            end
            MODE_QUERY:
            begin
                if (!memo_ok)
                begin
                    for (int unsigned i = 0; i < fill_mark && i < SLOTS; i++)
                    begin
                        if (slot_used[i] && (!memo_ok || slot_val[i] < memo_min))
                        begin
                            memo_min = slot_val[i];
                            memo_ok  = 1'b1;
                        end
                    end
                end
                if (memo_ok)
                begin
                    res.min_valid = 1'b1;
                    res.min_value = memo_min;
                end
            end
            default:
            begin
                // unused opcode: no effect, status ok
                res.status = ST_OK;
            end
        endcase
        return res;
    endfunction

    // Predict on request beats, compare on result beats
    always @(posedge clk or negedge rst_n)
    begin
        table_result_t got;
        table_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_val[i]  = '0;
                slot_used[i] = 1'b0;
            end
            for (int i = 0; i < THREADS; i++)
            begin
                hint_slot[i] = 0;
                hint_ok[i]   = 1'b0;
            end
            fill_mark = 0;
            memo_ok   = 1'b0;
            memo_min  = '0;
            expected_results.delete();
            mismatches = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                expected_results.push_back(
                    table_step(in_ch.mode, in_ch.seq_value, in_ch.thread_id));

            if (out_ch.valid && out_ch.ready)
            begin
                got.status    = out_ch.status;
                got.min_valid = out_ch.min_valid;
                got.min_value = out_ch.min_value;
                if (expected_results.size() == 0)
                begin
                    $error("result beat with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        mismatches++;
                    end
                    if (got.min_valid !== want.min_valid)
                    begin
                        $error("min_valid: expected %0d, got %0d",
                               want.min_valid, got.min_valid);
                        mismatches++;
                    end
                    if (got.min_value !== want.min_value)
                    begin
                        $error("min_value: expected 0x%016h, got 0x%016h",
                               want.min_value, got.min_value);
                        mismatches++;
                    end
                end
            end
        end
        error_count <= mismatches;
        outstanding <= expected_results.size();
    end

endmodule

// ----- verif/testbench.sv -----
module testbench;
    import amst_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [VALUE_W-1:0] VALUE_MAX  = {VALUE_W{1'b1}};
    localparam int RANDOM_BLOCKS = 15;
    localparam int BLOCK_ITEMS   = 100;
    localparam int HOLD_AT_BEAT  = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_LIMIT    = 3000;
    localparam int DRAIN_CYCLES  = 40;

    logic clk;
    logic rst_n;
    int   error_count;
    int   outstanding;
    int   idle_cycles = 0;
    bit   sender_bursting;

    // Values added recently, used to aim removes at stored entries
    logic [VALUE_W-1:0] value_pool [$];

    amst_in_if  req_ch ();
    amst_out_if rsp_ch ();

    aggregate_minimum_slot_table uut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (req_ch),
        .out   (rsp_ch)
    );

    min_table_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (req_ch),
        .out_ch      (rsp_ch),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Offer one request beat; returns at the edge it is taken
    task automatic offer_request(
        input logic [MODE_W-1:0]  op,
        input logic [VALUE_W-1:0] value,
        input logic [TID_W-1:0]   tid
    );
        int gap;
        gap = sender_bursting ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.mode      <= op;
        req_ch.seq_value <= value;
        req_ch.thread_id <= tid;
        if (op == MODE_ADD)
        begin
            value_pool.push_back(value);
            if (value_pool.size() > 40)
                void'(value_pool.pop_front());
        end
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] draw_value(input bit narrow);
        logic [63:0] raw;
        int unsigned pick;
        pick = $urandom_range(0, 19);
        raw  = {$urandom, $urandom};
        if (pick == 0)
            return '0;
        if (pick == 1)
            return VALUE_MAX;
        if (narrow)
            return VALUE_W'(raw % 24);
        return raw[VALUE_W-1:0];
    endfunction

    // Mostly a recently added value, sometimes a fresh random one
    function automatic logic [VALUE_W-1:0] draw_remove_value(input bit narrow);
        int idx;
        logic [VALUE_W-1:0] v;
        if (value_pool.size() > 0 && $urandom_range(0, 9) < 8)
        begin
            idx = $urandom_range(0, value_pool.size() - 1);
            v   = value_pool[idx];
            value_pool.delete(idx);
            return v;
        end
        return draw_value(narrow);
    endfunction

    // Request side: reset, directed beats, then random blocks
    initial
    begin
        int unsigned add_pct;
        int unsigned roll;
        bit          narrow;
        logic [MODE_W-1:0]  op;
        logic [VALUE_W-1:0] value;

        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.mode      <= MODE_ADD;
        req_ch.seq_value <= '0;
        req_ch.thread_id <= '0;
        sender_bursting  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, misses, unused opcode
        offer_request(MODE_QUERY, '0, 3'd0);
        offer_request(MODE_REMOVE, 63'd5, 3'd1);
        offer_request(MODE_UNUSED, VALUE_MAX, 3'd7);
        // extremes, memo build and drop, hinted remove and reuse
        offer_request(MODE_ADD, VALUE_MAX, 3'd0);
        offer_request(MODE_ADD, '0, 3'd7);
        offer_request(MODE_QUERY, '0, 3'd2);
        offer_request(MODE_REMOVE, '0, 3'd7);
        offer_request(MODE_QUERY, VALUE_MAX, 3'd2);
        offer_request(MODE_ADD, VALUE_W'({32{2'b10}}), 3'd7);
        offer_request(MODE_ADD, VALUE_W'({31{2'b01}}), 3'd3);
        offer_request(MODE_QUERY, '0, 3'd4);
        // remove through the scan, no hint for this thread
        offer_request(MODE_REMOVE, VALUE_MAX, 3'd2);
        // fill every slot, then one add too many
        for (int i = 0; i < 14; i++)
            offer_request(MODE_ADD, VALUE_W'(100 + 7 * i), TID_W'(i));
        offer_request(MODE_ADD, 63'd1, 3'd5);

        // random blocks, each with its own mix and value spread
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            case ($urandom_range(0, 2))
                0: add_pct = 30;
                1: add_pct = 50;
                default: add_pct = 70;
            endcase
            narrow          = $urandom_range(0, 1);
            sender_bursting = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < BLOCK_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 2)
                begin
                    op    = MODE_UNUSED;
                    value = draw_value(1'b0);
                end
                else if (roll < 17)
                begin
                    op    = MODE_QUERY;
                    value = draw_value(1'b0);
                end
                else if ($urandom_range(0, 99) < add_pct)
                begin
                    op    = MODE_ADD;
                    value = draw_value(narrow);
                end
                else
                begin
                    op    = MODE_REMOVE;
                    value = draw_remove_value(narrow);
                end
                offer_request(op, value, TID_W'($urandom_range(0, 7)));
            end
        end
        req_ch.valid <= 1'b0;

        // drain, then let the block settle
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: random stalls, quiet stretches, one long hold-off
    initial
    begin
        int  stall;
        int  beats_taken;
        bit  held;
        bit  steady;

        rsp_ch.ready <= 1'b0;
        beats_taken  = 0;
        held         = 1'b0;
        steady       = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (beats_taken % 64 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (!held && beats_taken == HOLD_AT_BEAT)
            begin
                held  = 1'b1;
                stall = HOLD_CYCLES;
            end
            else
                stall = steady ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
            beats_taken++;
        end
    end

    // Watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

// ----- aggregate_minimum_slot_table.f -----
+incdir+src
src/amst_pkg.sv
src/amst_if.sv
src/amst_ram.sv
src/aggregate_minimum_slot_table.sv
verif/min_table_checker.sv
verif/testbench.sv
